### src/ljsd_pkg.sv
// ----------------------------------------------------------------------------
// ljsd_pkg
// Shared types, constants and table lookups for the lossless scan decoder.
// ----------------------------------------------------------------------------
package ljsd_pkg;

	localparam int MAX_WIDTH       = 8192;
	localparam int ADDR_W          = $clog2(MAX_WIDTH);
	localparam int MAX_CODE_LENGTH = 16;
	localparam int NUM_SYMBOLS     = 17;
	localparam int CFG_DATA_W      = 45;

	localparam logic [2:0] REG_COUNTS_SHORT  = 3'd0;
	localparam logic [2:0] REG_COUNTS_LONG   = 3'd1;
	localparam logic [2:0] REG_SYMBOLS_FIRST = 3'd2;
	localparam logic [2:0] REG_SYMBOLS_REST  = 3'd3;
	localparam logic [2:0] REG_LINE_WIDTH    = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;
	localparam logic [2:0] REG_PRECISION     = 3'd6;
	localparam logic [2:0] REG_PREDICTOR     = 3'd7;

	localparam logic [2:0] PRED_NONE = 3'd0;
	localparam logic [2:0] PRED_A    = 3'd1;
	localparam logic [2:0] PRED_B    = 3'd2;
	localparam logic [2:0] PRED_C    = 3'd3;
	localparam logic [2:0] PRED_ABC  = 3'd4;
	localparam logic [2:0] PRED_ABC2 = 3'd5;
	localparam logic [2:0] PRED_BAC2 = 3'd6;
	localparam logic [2:0] PRED_AVG  = 3'd7;

	localparam logic [7:0] MARKER_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [39:0] counts_short;
		logic [39:0] counts_long;
		logic [44:0] symbols_first;
		logic [39:0] symbols_rest;
	} huff_cfg_t;

	typedef struct packed {
		logic [13:0] line_width;
		logic [15:0] frame_height;
		logic [4:0]  sample_precision;
		logic [2:0]  predictor_select;
	} recon_cfg_t;

	typedef struct packed {
		logic        valid;
		logic        bad;
		logic [15:0] diff;
	} bit_res_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        row_last;
		logic        frame_last;
		logic        frame_done;
	} pix_res_t;

	// number of codes of a given length, zero outside 1..16
	function automatic logic [4:0] count_of(huff_cfg_t c, logic [4:0] len);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < 8; i++) begin
			if (len == 5'(i + 1)) r = c.counts_short[5*i +: 5];
			if (len == 5'(i + 9)) r = c.counts_long[5*i +: 5];
		end
		return r;
	endfunction

	function automatic logic [4:0] symbol_at(huff_cfg_t c, logic [4:0] idx);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < 9; i++) begin
			if (idx == 5'(i)) r = c.symbols_first[5*i +: 5];
		end
		for (int i = 0; i < 8; i++) begin
			if (idx == 5'(i + 9)) r = c.symbols_rest[5*i +: 5];
		end
		return r;
	endfunction

endpackage

### src/ljsd_ram.sv
// ----------------------------------------------------------------------------
// ljsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ljsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### src/ljsd_bitdec.sv
// ----------------------------------------------------------------------------
// ljsd_bitdec
// One-bit-per-step canonical Huffman and extra-bit decoder.
// ----------------------------------------------------------------------------
module ljsd_bitdec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                bit_en,
	input  logic                bit_val,
	input  ljsd_pkg::huff_cfg_t cfg,
	output ljsd_pkg::bit_res_t  res
);

	logic [15:0] code_acc_q;
	logic [4:0]  code_len_q;
	logic [21:0] first_q;
	logic [9:0]  base_q;
	logic        reading_extra_q;
	logic [4:0]  category_q;
	logic [15:0] extra_acc_q;
	logic [4:0]  extra_cnt_q;

	logic [15:0] acc_n;
	logic [4:0]  len_n;
	logic [4:0]  cnt_prev;
	logic [4:0]  cnt_cur;
	logic [21:0] first_n;
	logic [9:0]  base_n;
	logic [21:0] offset;
	logic        hit;
	logic [9:0]  sym_idx;
	logic [4:0]  sym;
	logic [15:0] eacc_n;
	logic [4:0]  ecnt_n;
	logic [15:0] half;
	logic [15:0] extra_diff;

	// per-length first code and symbol base carried from the previous bit
	always_comb begin
		acc_n    = {code_acc_q[14:0], bit_val};
		len_n    = code_len_q + 5'd1;
		cnt_prev = ljsd_pkg::count_of(cfg, code_len_q);
		cnt_cur  = ljsd_pkg::count_of(cfg, len_n);
		if (code_len_q == 5'd0) begin
			first_n = 22'd0;
			base_n  = 10'd0;
		end else begin
			first_n = 22'((first_q + 22'(cnt_prev)) << 1);
			base_n  = base_q + 10'(cnt_prev);
		end
		offset  = 22'(acc_n) - first_n;
		hit     = (22'(acc_n) >= first_n) && (offset < 22'(cnt_cur));
		sym_idx = base_n + offset[9:0];
		sym     = ljsd_pkg::symbol_at(cfg, sym_idx[4:0]);

		eacc_n     = {extra_acc_q[14:0], bit_val};
		ecnt_n     = extra_cnt_q + 5'd1;
		half       = 16'(17'd1 << (category_q - 5'd1));
		extra_diff = eacc_n;
		if (eacc_n < half) extra_diff = 16'(17'(eacc_n) + 17'd1 - (17'd1 << category_q));

		res = '0;
		if (reading_extra_q) begin
			if (ecnt_n >= category_q) begin
				res.valid = 1'b1;
				res.diff  = extra_diff;
			end
		end else if (hit) begin
			if (sym_idx >= 10'(ljsd_pkg::NUM_SYMBOLS) || sym > 5'd16) begin
				res.valid = 1'b1;
				res.bad   = 1'b1;
			end else if (sym == 5'd0) begin
				res.valid = 1'b1;
			end else if (sym == 5'd16) begin
				res.valid = 1'b1;
				res.diff  = 16'h8000;
			end
		end else if (len_n >= 5'(ljsd_pkg::MAX_CODE_LENGTH)) begin
			res.valid = 1'b1;
			res.bad   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_acc_q      <= '0;
			code_len_q      <= '0;
			first_q         <= '0;
			base_q          <= '0;
			reading_extra_q <= 1'b0;
			category_q      <= '0;
			extra_acc_q     <= '0;
			extra_cnt_q     <= '0;
		end else if (clear) begin
			code_acc_q      <= '0;
			code_len_q      <= '0;
			first_q         <= '0;
			base_q          <= '0;
			reading_extra_q <= 1'b0;
			category_q      <= '0;
			extra_acc_q     <= '0;
			extra_cnt_q     <= '0;
		end else if (bit_en) begin
			if (reading_extra_q) begin
				if (ecnt_n >= category_q) begin
					reading_extra_q <= 1'b0;
					category_q      <= '0;
					extra_acc_q     <= '0;
					extra_cnt_q     <= '0;
				end else begin
					extra_acc_q <= eacc_n;
					extra_cnt_q <= ecnt_n;
				end
			end else if (hit || res.valid) begin
				code_acc_q <= '0;
				code_len_q <= '0;
				first_q    <= '0;
				base_q     <= '0;
				if (!res.valid) begin
					reading_extra_q <= 1'b1;
					category_q      <= sym;
					extra_acc_q     <= '0;
					extra_cnt_q     <= '0;
				end
			end else begin
				code_acc_q <= acc_n;
				code_len_q <= len_n;
				first_q    <= first_n;
				base_q     <= base_n;
			end
		end
	end

endmodule

### src/ljsd_recon.sv
// ----------------------------------------------------------------------------
// ljsd_recon
// Prediction, pixel reconstruction, position tracking and line store.
// ----------------------------------------------------------------------------
module ljsd_recon (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 emit_en,
	input  logic [15:0]          diff,
	input  ljsd_pkg::recon_cfg_t cfg,
	output ljsd_pkg::pix_res_t   res
);

	logic [ljsd_pkg::ADDR_W-1:0] column_q;
	logic [15:0]                 row_q;
	logic [15:0]                 left_q;
	logic [15:0]                 above_left_q;
	logic                        frame_done_q;

	logic [15:0]                 above;
	logic [13:0]                 w;
	logic [ljsd_pkg::ADDR_W-1:0] w_m1;
	logic [15:0]                 h_m1;
	logic [4:0]                  prec;
	logic signed [17:0]          sa, sb, sc, pred;
	logic [15:0]                 pix;
	logic                        row_end, frame_end;

	ljsd_ram #(
		.WIDTH(16),
		.DEPTH(ljsd_pkg::MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (emit_en),
		.waddr(column_q),
		.wdata(pix),
		.raddr(column_q),
		.rdata(above)
	);

	always_comb begin
		if (cfg.line_width == 14'd0) w = 14'd1;
		else if (cfg.line_width > 14'(ljsd_pkg::MAX_WIDTH)) w = 14'(ljsd_pkg::MAX_WIDTH);
		else w = cfg.line_width;
		w_m1 = ljsd_pkg::ADDR_W'(w - 14'd1);
		h_m1 = (cfg.frame_height == 16'd0) ? 16'd0 : cfg.frame_height - 16'd1;
		if (cfg.sample_precision < 5'd2) prec = 5'd2;
		else if (cfg.sample_precision > 5'd16) prec = 5'd16;
		else prec = cfg.sample_precision;

		sa = $signed({2'b00, left_q});
		sb = $signed({2'b00, above});
		sc = $signed({2'b00, above_left_q});

		if (row_q == 16'd0 && column_q == '0) pred = $signed({2'b00, 16'(17'd1 << (prec - 5'd1))});
		else if (row_q == 16'd0) pred = sa;
		else if (column_q == '0) pred = sb;
		else begin
			unique case (cfg.predictor_select)
				ljsd_pkg::PRED_NONE: pred = '0;
				ljsd_pkg::PRED_A:    pred = sa;
				ljsd_pkg::PRED_B:    pred = sb;
				ljsd_pkg::PRED_C:    pred = sc;
				ljsd_pkg::PRED_ABC:  pred = sa + sb - sc;
				ljsd_pkg::PRED_ABC2: pred = sa + ((sb - sc) >>> 1);
				ljsd_pkg::PRED_BAC2: pred = sb + ((sa - sc) >>> 1);
				ljsd_pkg::PRED_AVG:  pred = (sa + sb) >>> 1;
				default:             pred = '0;
			endcase
		end
		pix       = pred[15:0] + diff;
		row_end   = column_q >= w_m1;
		frame_end = row_end && (row_q >= h_m1);

		res.pixel      = pix;
		res.row_last   = row_end;
		res.frame_last = frame_end;
		res.frame_done = frame_done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			left_q       <= '0;
			above_left_q <= '0;
			frame_done_q <= 1'b0;
		end else if (clear) begin
			column_q     <= '0;
			row_q        <= '0;
			left_q       <= '0;
			above_left_q <= '0;
			frame_done_q <= 1'b0;
		end else if (emit_en) begin
			left_q       <= pix;
			above_left_q <= above;
			if (row_end) begin
				column_q <= '0;
				if (frame_end) begin
					row_q        <= '0;
					frame_done_q <= 1'b1;
				end else begin
					row_q <= row_q + 16'd1;
				end
			end else begin
				column_q <= column_q + ljsd_pkg::ADDR_W'(1);
			end
		end
	end

endmodule

### src/lossless_jpeg_scan_decoder_unit.sv
// ----------------------------------------------------------------------------
// lossless_jpeg_scan_decoder_unit
// Lossless JPEG scan decoder: unstuffs bytes, decodes Huffman categories
// bit by bit and reconstructs pixels against a one-line store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | data_byte, scan_start
//  out     | output    | out_valid/out_stall| pixel, row_last, frame_last, bad_code
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  A byte is accepted in S_IDLE, then its bits go one at a time through the shared
//  bit decoder in S_BIT, with an S_EMIT step for each result; a dropped stuffed
//  byte is taken in S_IDLE alone. A byte yields up to eight results.
//  No clearing pass after reset; the line store is valid once written.
//  A result waits in the emit step until the output register is free.
// ----------------------------------------------------------------------------
module lossless_jpeg_scan_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            scan_start,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     pixel,
	output logic                            row_last,
	output logic                            frame_last,
	output logic                            bad_code,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [ljsd_pkg::CFG_DATA_W-1:0] cfg_data
);

	ljsd_pkg::huff_cfg_t  hcfg_q;
	ljsd_pkg::recon_cfg_t rcfg_q;

	ljsd_pkg::state_t state_q, state_d;
	logic [7:0]  byte_q;
	logic [2:0]  bit_idx_q, bit_idx_d;
	logic        after_ff_q, after_ff_d;
	logic        res_bad_q;
	logic [15:0] res_diff_q;
	logic        out_valid_q;

	logic               accept, ff_eff, clear, bit_en, emit_en, fire, slot, latch;
	ljsd_pkg::bit_res_t bres;
	ljsd_pkg::pix_res_t pres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcfg_q                  <= '0;
			rcfg_q.line_width       <= 14'd1;
			rcfg_q.frame_height     <= 16'd1;
			rcfg_q.sample_precision <= 5'd12;
			rcfg_q.predictor_select <= ljsd_pkg::PRED_A;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ljsd_pkg::REG_COUNTS_SHORT:  hcfg_q.counts_short <= cfg_data[39:0];
				ljsd_pkg::REG_COUNTS_LONG:   hcfg_q.counts_long <= cfg_data[39:0];
				ljsd_pkg::REG_SYMBOLS_FIRST: hcfg_q.symbols_first <= cfg_data[44:0];
				ljsd_pkg::REG_SYMBOLS_REST:  hcfg_q.symbols_rest <= cfg_data[39:0];
				ljsd_pkg::REG_LINE_WIDTH:    rcfg_q.line_width <= cfg_data[13:0];
				ljsd_pkg::REG_FRAME_HEIGHT:  rcfg_q.frame_height <= cfg_data[15:0];
				ljsd_pkg::REG_PRECISION:     rcfg_q.sample_precision <= cfg_data[4:0];
				ljsd_pkg::REG_PREDICTOR:     rcfg_q.predictor_select <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	ljsd_bitdec u_bitdec (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.bit_en (bit_en),
		.bit_val(byte_q[bit_idx_q]),
		.cfg    (hcfg_q),
		.res    (bres)
	);

	ljsd_recon u_recon (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.emit_en(emit_en),
		.diff   (res_diff_q),
		.cfg    (rcfg_q),
		.res    (pres)
	);

	assign in_stall  = (state_q != ljsd_pkg::S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign ff_eff    = after_ff_q && !scan_start;
	assign clear     = accept && scan_start;
	assign slot      = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		bit_idx_d  = bit_idx_q;
		after_ff_d = after_ff_q;
		bit_en     = 1'b0;
		latch      = 1'b0;
		fire       = 1'b0;
		emit_en    = 1'b0;
		unique case (state_q)
			ljsd_pkg::S_IDLE: begin
				if (accept) begin
					if (ff_eff) begin
						after_ff_d = 1'b0;
					end else begin
						after_ff_d = (data_byte == ljsd_pkg::MARKER_BYTE);
						bit_idx_d  = 3'd7;
						state_d    = ljsd_pkg::S_BIT;
					end
				end
			end
			ljsd_pkg::S_BIT: begin
				bit_en = !pres.frame_done;
				if (bit_en && bres.valid) begin
					latch   = 1'b1;
					state_d = ljsd_pkg::S_EMIT;
				end else if (bit_idx_q == 3'd0) begin
					state_d = ljsd_pkg::S_IDLE;
				end else begin
					bit_idx_d = bit_idx_q - 3'd1;
				end
			end
			ljsd_pkg::S_EMIT: begin
				if (slot) begin
					fire    = 1'b1;
					emit_en = !res_bad_q;
					if (bit_idx_q == 3'd0) begin
						state_d = ljsd_pkg::S_IDLE;
					end else begin
						bit_idx_d = bit_idx_q - 3'd1;
						state_d   = ljsd_pkg::S_BIT;
					end
				end
			end
			default: state_d = ljsd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ljsd_pkg::S_IDLE;
			bit_idx_q   <= '0;
			after_ff_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			bit_idx_q  <= bit_idx_d;
			after_ff_q <= after_ff_d;
			if (fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) byte_q <= data_byte;
		if (latch) begin
			res_bad_q  <= bres.bad;
			res_diff_q <= bres.diff;
		end
		if (fire) begin
			pixel      <= res_bad_q ? 16'd0 : pres.pixel;
			row_last   <= !res_bad_q && pres.row_last;
			frame_last <= !res_bad_q && pres.frame_last;
			bad_code   <= res_bad_q;
		end
	end

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_code |-> pixel == 16'd0 && !row_last && !frame_last)
		else $error("bad code result carries pixel data");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> row_last)
		else $error("frame end without row end");

	a_start_bits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !ff_eff |=> state_q == ljsd_pkg::S_BIT && bit_idx_q == 3'd7)
		else $error("accepted byte did not start bit decoding");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !out_valid_q || !out_stall)
		else $error("result overwrote a stalled transfer");

endmodule
